// File: rtl/core/pdr_pkg.sv
package pdr_pkg;

   // Field widths
   localparam int KEY_W        = 8;
   localparam int TIME_W       = 16;
   localparam int SPEED_W      = 18;
   localparam int ANGLE_W      = 32;
   localparam int POS_W        = 32;
   localparam int QUAT_W       = 16;
   localparam int LIN_VEL_W    = 19;
   localparam int ANG_VEL_W    = 33;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 32;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int ATAN_ENTRIES          = 24;
   localparam int ATAN_IDX_W            = 5;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_FWD   = 8'd119;
   localparam logic [KEY_W-1:0] KEY_BACK  = 8'd115;
   localparam logic [KEY_W-1:0] KEY_LEFT  = 8'd97;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 8'd100;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_SPEED      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_RATE         = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEP_TIME     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_STEP_TIME = 8'd3;

   // Register reset values
   localparam logic [SPEED_W-1:0] LINEAR_SPEED_RST      = 18'd19661;
   localparam logic [ANGLE_W-1:0] TURN_RATE_RST         = 32'd683565276;
   localparam logic [TIME_W-1:0]  MAX_STEP_TIME_RST     = 16'd6554;
   localparam logic [TIME_W-1:0]  DEFAULT_STEP_TIME_RST = 16'd3277;

   // CORDIC gain limit, Q1.30
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   typedef logic signed [31:0] unit_type;

   // arctan(2^-i) in binary angle units
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/pdr_req_if.sv
interface pdr_req_if;
   logic                           valid;
   logic                           ready;
   logic [pdr_pkg::KEY_W-1:0]      key_code;
   logic [pdr_pkg::TIME_W-1:0]     elapsed_time;

   modport source (output valid, output key_code, output elapsed_time, input ready);
   modport sink   (input valid, input key_code, input elapsed_time, output ready);
endinterface

// File: rtl/core/pdr_rsp_if.sv
interface pdr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pdr_pkg::POS_W-1:0]      x_position;
   logic signed [pdr_pkg::POS_W-1:0]      y_position;
   logic        [pdr_pkg::ANGLE_W-1:0]    heading;
   logic signed [pdr_pkg::QUAT_W-1:0]     quat_z;
   logic signed [pdr_pkg::QUAT_W-1:0]     quat_w;
   logic signed [pdr_pkg::LIN_VEL_W-1:0]  linear_velocity;
   logic signed [pdr_pkg::ANG_VEL_W-1:0]  angular_velocity;

   modport source (output valid, output x_position, output y_position, output heading,
                   output quat_z, output quat_w, output linear_velocity,
                   output angular_velocity, input ready);
   modport sink   (input valid, input x_position, input y_position, input heading,
                   input quat_z, input quat_w, input linear_velocity,
                   input angular_velocity, output ready);
endinterface

// File: rtl/core/pdr_csr_if.sv
interface pdr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pdr_pkg::CSR_INDEX_W-1:0]   reg_index;
   logic [pdr_pkg::CSR_DATA_W-1:0]    wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/core/pose_dead_reckoning_integrator.sv
// Channel   Port      Dir   Payload
// input     req_bus   in    key_code[7:0], elapsed_time[15:0]
// result    rsp_bus   out   x/y_position, heading, quat_z/w, linear/angular_velocity
// config    csr_bus   in    reg_index[7:0], wdata[31:0]
//
// Each item runs from accept to result through two passes of the shared CORDIC stage
// plus the shared multiplier steps for heading, x and y; the next item can be accepted
// only once this one has reached the output register and the sequencer is idle.
// req ready is high only while idle.
// Synchronous active-high reset restores register defaults and a zero pose.
// A finished result sits in the output register; the next item is accepted meanwhile,
// and the sequencer waits at its end only if the previous result is still untaken.
module pose_dead_reckoning_integrator #(
   parameter int CORDIC_ITERATIONS = pdr_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pdr_req_if.sink     req_bus,
   pdr_rsp_if.source   rsp_bus,
   pdr_csr_if.sink     csr_bus
);

   localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DELTA = 4'd1;
   localparam logic [3:0] ST_HEAD  = 4'd2;
   localparam logic [3:0] ST_CINIT = 4'd3;
   localparam logic [3:0] ST_CITER = 4'd4;
   localparam logic [3:0] ST_CEND  = 4'd5;
   localparam logic [3:0] ST_MULV  = 4'd6;
   localparam logic [3:0] ST_MULD  = 4'd7;
   localparam logic [3:0] ST_ACC   = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   localparam logic signed [31:0] UNIT_MAX = 32'sd1073741824;
   localparam logic signed [31:0] UNIT_MIN = -32'sd1073741824;
   localparam logic signed [37:0] POS_MAX  = 38'sd2147483647;
   localparam logic signed [37:0] POS_MIN  = -38'sd2147483648;
   localparam logic signed [31:0] QUAT_MAX = 32'sd32767;

   function automatic pdr_pkg::unit_type clamp_unit(input logic signed [31:0] v);
      pdr_pkg::unit_type r;
      if (v > UNIT_MAX) r = UNIT_MAX;
      else if (v < UNIT_MIN) r = UNIT_MIN;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [15:0] quat_round(input logic signed [31:0] v);
      logic signed [31:0] r;
      r = (v + 32'sd16384) >>> 15;
      return (r > QUAT_MAX) ? 16'sd32767 : r[15:0];
   endfunction

   // configuration
   logic [pdr_pkg::SPEED_W-1:0] fwd_speed_ff, fwd_speed_in;
   logic [pdr_pkg::ANGLE_W-1:0] turn_rate_ff, turn_rate_in;
   logic [pdr_pkg::TIME_W-1:0]  max_step_ff, max_step_in;
   logic [pdr_pkg::TIME_W-1:0]  dflt_step_ff, dflt_step_in;

   // sequencer and datapath
   logic [3:0]               state_ff, state_in;
   logic                     pass_ff, pass_in;
   logic                     axis_ff, axis_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     flip_ff, flip_in;
   logic                     turn_ff, turn_in;
   logic [pdr_pkg::TIME_W-1:0] dt_ff, dt_in;
   logic signed [18:0]       speed_ff, speed_in;
   logic signed [32:0]       rate_ff, rate_in;
   logic signed [52:0]       prod_ff, prod_in;
   logic signed [31:0]       cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [31:0]       cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0]              head_ff, head_in;
   logic signed [15:0]       qz_ff, qz_in, qw_ff, qw_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [31:0]              out_head_ff, out_head_in;
   logic signed [15:0]       out_qz_ff, out_qz_in, out_qw_ff, out_qw_in;
   logic signed [18:0]       out_lin_ff, out_lin_in;
   logic signed [32:0]       out_ang_ff, out_ang_in;

   // combinational helpers
   logic [pdr_pkg::TIME_W-1:0] dt_sel;
   logic signed [32:0]       mul_a;
   logic signed [19:0]       mul_b;
   logic signed [52:0]       mul_p;
   logic signed [52:0]       rnd30, rnd16;
   logic signed [22:0]       v_rnd;
   logic [31:0]              delta;
   logic signed [36:0]       d_step;
   logic signed [31:0]       pos_sel;
   logic signed [37:0]       pos_sum;
   logic signed [31:0]       pos_sat;
   logic signed [31:0]       sh_x, sh_y, atan_val;
   logic [31:0]              ang, ang_q, ang_h;
   logic signed [31:0]       x_fin, y_fin;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.x_position       = out_x_ff;
   assign rsp_bus.y_position       = out_y_ff;
   assign rsp_bus.heading          = out_head_ff;
   assign rsp_bus.quat_z           = out_qz_ff;
   assign rsp_bus.quat_w           = out_qw_ff;
   assign rsp_bus.linear_velocity  = out_lin_ff;
   assign rsp_bus.angular_velocity = out_ang_ff;

   assign dt_sel = (req_bus.elapsed_time == '0 || req_bus.elapsed_time > max_step_ff)
                   ? dflt_step_ff : req_bus.elapsed_time;

   // shared multiplier operand select
   assign rnd30 = prod_ff + 53'sd536870912;
   assign rnd16 = prod_ff + 53'sd32768;
   assign v_rnd = rnd30[52:30];
   assign delta = rnd16[47:16];
   assign d_step = rnd16[52:16];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DELTA: begin
            mul_a = $signed({1'b0, turn_rate_ff});
            mul_b = $signed({4'b0, dt_ff});
         end
         ST_MULV: begin
            mul_a = 33'(axis_ff ? sin_ff : cos_ff);
            mul_b = 20'(speed_ff);
         end
         ST_MULD: begin
            mul_a = 33'(v_rnd);
            mul_b = $signed({4'b0, dt_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // position accumulate with saturation
   assign pos_sel = axis_ff ? pos_y_ff : pos_x_ff;
   assign pos_sum = 38'(pos_sel) + 38'(d_step);
   assign pos_sat = (pos_sum > POS_MAX) ? POS_MAX[31:0]
                  : (pos_sum < POS_MIN) ? POS_MIN[31:0] : pos_sum[31:0];

   // CORDIC micro-rotation
   assign sh_x     = cy_ff >>> iter_ff;
   assign sh_y     = cx_ff >>> iter_ff;
   assign atan_val = $signed(pdr_pkg::atan_entry(pdr_pkg::ATAN_IDX_W'(iter_ff)));

   // fold angle into [-1/4, 1/4) turn
   assign ang   = pass_ff ? {1'b0, head_ff[31:1]} : head_ff;
   assign ang_q = ang + 32'h4000_0000;
   assign ang_h = ang + 32'h8000_0000;

   assign x_fin = flip_ff ? -cx_ff : cx_ff;
   assign y_fin = flip_ff ? -cy_ff : cy_ff;

   always_comb begin
      fwd_speed_in = fwd_speed_ff;
      turn_rate_in = turn_rate_ff;
      max_step_in  = max_step_ff;
      dflt_step_in = dflt_step_ff;
      state_in     = state_ff;
      pass_in      = pass_ff;
      axis_in      = axis_ff;
      iter_in      = iter_ff;
      flip_in      = flip_ff;
      turn_in      = turn_ff;
      dt_in        = dt_ff;
      speed_in     = speed_ff;
      rate_in      = rate_ff;
      prod_in      = prod_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_head_in  = out_head_ff;
      out_qz_in    = out_qz_ff;
      out_qw_in    = out_qw_ff;
      out_lin_in   = out_lin_ff;
      out_ang_in   = out_ang_ff;

      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            pdr_pkg::CSR_LINEAR_SPEED:      fwd_speed_in = csr_bus.wdata[pdr_pkg::SPEED_W-1:0];
            pdr_pkg::CSR_TURN_RATE:         turn_rate_in = csr_bus.wdata;
            pdr_pkg::CSR_MAX_STEP_TIME:     max_step_in  = csr_bus.wdata[pdr_pkg::TIME_W-1:0];
            pdr_pkg::CSR_DEFAULT_STEP_TIME: dflt_step_in = csr_bus.wdata[pdr_pkg::TIME_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               dt_in    = dt_sel;
               speed_in = '0;
               rate_in  = '0;
               turn_in  = 1'b0;
               case (req_bus.key_code)
                  pdr_pkg::KEY_FWD:   speed_in = $signed({1'b0, fwd_speed_ff});
                  pdr_pkg::KEY_BACK:  speed_in = -$signed({1'b0, fwd_speed_ff});
                  pdr_pkg::KEY_LEFT: begin
                     rate_in = $signed({1'b0, turn_rate_ff});
                     turn_in = 1'b1;
                  end
                  pdr_pkg::KEY_RIGHT: begin
                     rate_in = -$signed({1'b0, turn_rate_ff});
                     turn_in = 1'b1;
                  end
                  default: ;
               endcase
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            prod_in  = mul_p;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            // sign of rate picks the turn direction
            if (turn_ff) head_in = rate_ff[32] ? head_ff - delta : head_ff + delta;
            pass_in  = 1'b0;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            flip_in  = ang_q[31];
            cz_in    = $signed(ang_q[31] ? ang_h : ang);
            cx_in    = pdr_pkg::CORDIC_GAIN;
            cy_in    = '0;
            iter_in  = '0;
            state_in = ST_CITER;
         end
         ST_CITER: begin
            if (!cz_ff[31]) begin
               cx_in = cx_ff - sh_x;
               cy_in = cy_ff + sh_y;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + sh_x;
               cy_in = cy_ff - sh_y;
               cz_in = cz_ff + atan_val;
            end
            if (iter_ff == ITER_LAST) state_in = ST_CEND;
            else iter_in = iter_ff + 1'b1;
         end
         ST_CEND: begin
            if (!pass_ff) begin
               cos_in   = clamp_unit(x_fin);
               sin_in   = clamp_unit(y_fin);
               axis_in  = 1'b0;
               state_in = ST_MULV;
            end else begin
               qw_in    = quat_round(clamp_unit(x_fin));
               qz_in    = quat_round(clamp_unit(y_fin));
               state_in = ST_DONE;
            end
         end
         ST_MULV: begin
            prod_in  = mul_p;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            prod_in  = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!axis_ff) begin
               pos_x_in = pos_sat;
               axis_in  = 1'b1;
               state_in = ST_MULV;
            end else begin
               pos_y_in = pos_sat;
               pass_in  = 1'b1;
               state_in = ST_CINIT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = pos_x_ff;
               out_y_in     = pos_y_ff;
               out_head_in  = head_ff;
               out_qz_in    = qz_ff;
               out_qw_in    = qw_ff;
               out_lin_in   = speed_ff;
               out_ang_in   = rate_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_speed_ff <= pdr_pkg::LINEAR_SPEED_RST;
         turn_rate_ff <= pdr_pkg::TURN_RATE_RST;
         max_step_ff  <= pdr_pkg::MAX_STEP_TIME_RST;
         dflt_step_ff <= pdr_pkg::DEFAULT_STEP_TIME_RST;
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         axis_ff      <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_speed_ff <= fwd_speed_in;
         turn_rate_ff <= turn_rate_in;
         max_step_ff  <= max_step_in;
         dflt_step_ff <= dflt_step_in;
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         axis_ff      <= axis_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      flip_ff     <= flip_in;
      turn_ff     <= turn_in;
      dt_ff       <= dt_in;
      speed_ff    <= speed_in;
      rate_ff     <= rate_in;
      prod_ff     <= prod_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      qz_ff       <= qz_in;
      qw_ff       <= qw_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
      out_qz_ff   <= out_qz_in;
      out_qw_ff   <= out_qw_in;
      out_lin_ff  <= out_lin_in;
      out_ang_ff  <= out_ang_in;
   end

endmodule
